// ===== sv/ndr_pkg.sv =====
// Shared types and constants of the neutral-drift resampler.
package ndr_pkg;

  // Fixed widths of the stream and configuration fields.
  localparam int DRAW_BITS  = 31;
  localparam int FIELD_W    = 11;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  // Width of the generation stamp kept per colour.
  localparam int EPOCH_W = 8;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_COLOR,
    ST_TAG,
    ST_CLOSE
  } ndr_state_t;

endpackage

// ===== sv/ndr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module ndr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/neutral_drift_resampler.sv =====
// Neutral-drift resampler top level: bit-serial parent selection and population banks.
//
// Each input word makes one child: its parent index is the draw modulo the
// current generation size, found by a restoring remainder that takes one draw
// bit per cycle; an item passes through accept, the remainder bits, a bank
// read, a colour write and a presence check, and a child dropped for lack of
// room skips the presence check. The word flagged last then passes through a
// close step that ends the generation and loads the result register, and waits
// there only if the previous result has not yet been taken. Colour presence is
// kept as a generation stamp per colour; after reset, after a write of
// start_population and once every 255 generations a clearing pass rewrites the
// stamps of all MAX_POP colours, during which no input word is accepted.
// Children beyond MAX_POP are dropped and reported through tuser.
module neutral_drift_resampler
  import ndr_pkg::*;
#(
  parameter int MAX_POP    = 1024,
  parameter int DRAW_WIDTH = 31
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration: start_population.
  input  logic                  cfg_wr_en,
  input  logic [FIELD_W-1:0]    cfg_wr_data,
  // Input stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [30:0] random_draw, [31] zero
  input  logic                  s_axis_tlast,   // last_in_generation
  // Result stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [10:0] colors_alive,
                                                // [21:11] generation_size, [23:22] zero
  output logic                  m_axis_tuser    // size_overflow
);

  localparam int IW = (MAX_POP > 1) ? $clog2(MAX_POP) : 1;
  localparam int CW = $clog2(MAX_POP + 1);
  localparam int DW = (DRAW_WIDTH < DRAW_BITS) ? DRAW_WIDTH : DRAW_BITS;
  localparam int BW = (DW > 1) ? $clog2(DW) : 1;
  localparam int RESET_POP = (MAX_POP < 1024) ? MAX_POP : 1024;

  ndr_state_t state, state_next;

  logic [CW-1:0]      current_size;
  logic [CW-1:0]      children_written;
  logic [CW-1:0]      alive_tally;
  logic               overflow_seen;
  logic               bank_select;
  logic               a_identity;
  logic [EPOCH_W-1:0] epoch;
  logic [IW-1:0]      clr_addr;

  logic [DW-1:0]      draw_sr;
  logic [BW-1:0]      bit_cnt;
  logic [CW-1:0]      rem;
  logic               last_item;
  logic [IW-1:0]      color_q;

  logic               out_valid;
  logic [FIELD_W-1:0] out_alive;
  logic [FIELD_W-1:0] out_size;
  logic               out_ovf;

  logic [CW-1:0]      div_size;
  logic [CW:0]        trial;
  logic [CW-1:0]      rem_next;
  logic [IW-1:0]      parent;
  logic [IW-1:0]      color;
  logic [IW-1:0]      bank_a_rdata;
  logic [IW-1:0]      bank_b_rdata;
  logic [EPOCH_W-1:0] tag_rdata;
  logic               room;
  logic               out_free;
  logic               clr_done;
  logic [EPOCH_W-1:0] epoch_inc;
  logic [CW-1:0]      cfg_pop;

  logic               bank_we_a;
  logic               bank_we_b;
  logic               tag_we;
  logic [IW-1:0]      tag_waddr;
  logic [EPOCH_W-1:0] tag_wdata;

  // Clamp a written start population into 1 .. MAX_POP.
  always_comb begin
    priority if (cfg_wr_data == '0) begin
      cfg_pop = CW'(1);
    end else if (32'(cfg_wr_data) > 32'(MAX_POP)) begin
      cfg_pop = CW'(MAX_POP);
    end else begin
      cfg_pop = CW'(cfg_wr_data);
    end
  end

  // One restoring remainder step per cycle.
  assign div_size = (current_size == '0) ? CW'(1) : current_size;
  assign trial    = {rem, draw_sr[DW-1]};
  assign rem_next = (trial >= {1'b0, div_size}) ? CW'(trial - {1'b0, div_size}) : CW'(trial);
  assign parent   = rem[IW-1:0];

  // Colour of the chosen parent: identity while bank a still holds its start contents.
  always_comb begin
    if (bank_select) begin
      color = bank_b_rdata;
    end else if (a_identity) begin
      color = parent;
    end else begin
      color = bank_a_rdata;
    end
  end

  assign room      = (32'(children_written) < 32'(MAX_POP));
  assign out_free  = !out_valid || m_axis_tready;
  assign clr_done  = (clr_addr == IW'(MAX_POP - 1));
  assign epoch_inc = epoch + 1'b1;

  // Memory write controls.
  assign bank_we_a = (state == ST_COLOR) && room && bank_select;
  assign bank_we_b = (state == ST_COLOR) && room && !bank_select;

  always_comb begin
    tag_we    = 1'b0;
    tag_waddr = color_q;
    tag_wdata = epoch;
    if (state == ST_CLEAR) begin
      tag_we    = 1'b1;
      tag_waddr = clr_addr;
      tag_wdata = '0;
    end else if (state == ST_TAG) begin
      tag_we = (tag_rdata != epoch);
    end
  end

  ndr_ram #(.WIDTH(IW), .DEPTH(MAX_POP)) u_bank_a (
    .clk   (clk),
    .we    (bank_we_a),
    .waddr (children_written[IW-1:0]),
    .wdata (color),
    .raddr (parent),
    .rdata (bank_a_rdata)
  );

  ndr_ram #(.WIDTH(IW), .DEPTH(MAX_POP)) u_bank_b (
    .clk   (clk),
    .we    (bank_we_b),
    .waddr (children_written[IW-1:0]),
    .wdata (color),
    .raddr (parent),
    .rdata (bank_b_rdata)
  );

  ndr_ram #(.WIDTH(EPOCH_W), .DEPTH(MAX_POP)) u_tags (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (color),
    .rdata (tag_rdata)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state; a configuration write always restarts with a clearing pass.
  always_comb begin
    state_next = state;
    if (cfg_wr_en) begin
      state_next = ST_CLEAR;
    end else begin
      unique case (state)
        ST_CLEAR: if (clr_done) state_next = ST_IDLE;
        ST_IDLE:  if (s_axis_tvalid) state_next = ST_DIV;
        ST_DIV:   if (bit_cnt == '0) state_next = ST_READ;
        ST_READ:  state_next = ST_COLOR;
        ST_COLOR: begin
          if (room) begin
            state_next = ST_TAG;
          end else begin
            state_next = last_item ? ST_CLOSE : ST_IDLE;
          end
        end
        ST_TAG:   state_next = last_item ? ST_CLOSE : ST_IDLE;
        ST_CLOSE: begin
          if (out_free) begin
            state_next = (epoch_inc == '0) ? ST_CLEAR : ST_IDLE;
          end
        end
        default:  state_next = ST_CLEAR;
      endcase
    end
  end

  // No word is taken in the cycle of a configuration write.
  assign s_axis_tready = (state == ST_IDLE) && !cfg_wr_en;

  // Generation control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_size     <= CW'(RESET_POP);
      children_written <= '0;
      alive_tally      <= '0;
      overflow_seen    <= 1'b0;
      bank_select      <= 1'b0;
      a_identity       <= 1'b1;
      epoch            <= EPOCH_W'(1);
      clr_addr         <= '0;
    end else if (cfg_wr_en) begin
      current_size     <= cfg_pop;
      children_written <= '0;
      alive_tally      <= '0;
      overflow_seen    <= 1'b0;
      bank_select      <= 1'b0;
      a_identity       <= 1'b1;
      epoch            <= EPOCH_W'(1);
      clr_addr         <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_done) begin
            clr_addr <= '0;
            epoch    <= EPOCH_W'(1);
          end
        end
        ST_COLOR: begin
          if (room) begin
            children_written <= children_written + 1'b1;
          end else begin
            overflow_seen <= 1'b1;
          end
        end
        ST_TAG: begin
          if (tag_rdata != epoch) begin
            alive_tally <= alive_tally + 1'b1;
          end
        end
        ST_CLOSE: begin
          if (out_free) begin
            current_size     <= children_written;
            bank_select      <= !bank_select;
            if (bank_select) begin
              a_identity <= 1'b0;
            end
            children_written <= '0;
            alive_tally      <= '0;
            overflow_seen    <= 1'b0;
            epoch            <= epoch_inc;
          end
        end
        default: ;
      endcase
    end
  end

  // Item datapath: draw shift register and remainder.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      draw_sr   <= s_axis_tdata[DW-1:0];
      last_item <= s_axis_tlast;
      bit_cnt   <= BW'(DW - 1);
      rem       <= '0;
    end else if (state == ST_DIV) begin
      draw_sr <= draw_sr << 1;
      bit_cnt <= bit_cnt - 1'b1;
      rem     <= rem_next;
    end
    if (state == ST_COLOR) begin
      color_q <= color;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_CLOSE && out_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLOSE && out_free) begin
      out_alive <= FIELD_W'(alive_tally);
      out_size  <= FIELD_W'(children_written);
      out_ovf   <= overflow_seen;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W - 2 * FIELD_W){1'b0}}, out_size, out_alive};
  assign m_axis_tuser  = out_ovf;

  // Distinct colours can never outnumber the children written.
  a_alive_bound: assert property (@(posedge clk) disable iff (rst)
    alive_tally <= children_written)
    else $error("colour tally exceeds children written");

  // The partial remainder stays below the divisor throughout the division.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < div_size)
    else $error("remainder out of range");

  // A result appears only as a generation closes.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_CLOSE)
    else $error("result loaded outside generation close");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the neutral-drift resampler, predicting each generation census.
module testbench
  import ndr_pkg::*;
();

  localparam int MAX_POP       = 1024;
  localparam int DRAW_WIDTH    = 31;
  localparam int COLOR_W       = $clog2(MAX_POP);
  localparam int SETTLE_CYCLES = 64;
  localparam logic [DRAW_BITS-1:0] DRAW_MASK =
    (DRAW_WIDTH >= DRAW_BITS) ? '1 : DRAW_BITS'((64'd1 << DRAW_WIDTH) - 1);

  // One child word on the input side and one generation census on the output side.
  typedef struct {
    logic [DRAW_BITS-1:0] draw;
    logic                 last;
  } child_word_t;

  typedef struct {
    logic [FIELD_W-1:0] alive;
    logic [FIELD_W-1:0] size;
    logic               overflow;
  } census_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [FIELD_W-1:0]    cfg_wr_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  // Words waiting to be sent and censuses waiting to arrive.
  child_word_t child_words [$];
  census_t     pending_census [$];
  int          words_queued = 0;
  int          words_taken = 0;
  int          mismatches = 0;

  // Idle control for both sides: a hold count per word and runs with no idling.
  int in_hold = 0;
  int in_calm = 0;
  int out_hold = 0;
  int out_calm = 0;

  // Predicted population state.
  logic [COLOR_W-1:0] lineage [2][MAX_POP];
  bit                 colour_seen [MAX_POP];
  bit                 cur_bank;
  logic [FIELD_W-1:0] start_pop;
  logic [FIELD_W-1:0] parent_count;
  logic [FIELD_W-1:0] kids;
  logic [FIELD_W-1:0] alive;
  logic               overflow;

  neutral_drift_resampler #(
    .MAX_POP   (MAX_POP),
    .DRAW_WIDTH(DRAW_WIDTH)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [30:0] random_draw, [31] zero
    .s_axis_tlast (s_axis_tlast),   // last_in_generation
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [10:0] colors_alive, [21:11] generation_size, [23:22] zero
    .m_axis_tuser (m_axis_tuser)    // size_overflow
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Start an empty generation under construction.
  function automatic void open_generation();
    int i;
    for (i = 0; i < MAX_POP; i++) colour_seen[i] = 1'b0;
    kids = '0;
    alive = '0;
    overflow = 1'b0;
  endfunction

  // Restart the population as identity colours from a new start size.
  function automatic void reseed_population(input logic [FIELD_W-1:0] value);
    int i;
    if (value == 0) start_pop = FIELD_W'(1);
    else if (value > MAX_POP) start_pop = FIELD_W'(MAX_POP);
    else start_pop = value;
    for (i = 0; i < MAX_POP; i++) begin
      lineage[0][i] = COLOR_W'(i);
      lineage[1][i] = '0;
    end
    cur_bank = 1'b0;
    parent_count = start_pop;
    open_generation();
  endfunction

  // One child: pick the parent, inherit its colour, and close the generation on last.
  function automatic void breed_child(input logic [DRAW_BITS-1:0] draw, input logic last);
    logic [DRAW_BITS-1:0] used;
    int unsigned          parent;
    logic [COLOR_W-1:0]   colour;
    census_t              report;
    used = draw & DRAW_MASK;
    parent = 32'(used % parent_count);
    if (parent >= MAX_POP) parent = MAX_POP - 1;
    colour = lineage[cur_bank][parent[COLOR_W-1:0]];
    if (kids < MAX_POP) begin
      lineage[!cur_bank][kids[COLOR_W-1:0]] = colour;
      kids++;
      if (!colour_seen[colour]) begin
        colour_seen[colour] = 1'b1;
        alive++;
      end
    end else begin
      overflow = 1'b1;
    end
    if (last) begin
      report.alive = alive;
      report.size = kids;
      report.overflow = overflow;
      pending_census.push_back(report);
      parent_count = kids;
      cur_bank = !cur_bank;
      open_generation();
    end
  endfunction

  // Draws lean on the extremes now and then; most are full-width random values.
  function automatic logic [DRAW_BITS-1:0] pick_draw();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return DRAW_BITS'($urandom_range(0, 2047));
      default: return DRAW_BITS'($urandom());
    endcase
  endfunction

  // Input driver: one word in flight, with a random hold after each accepted word.
  always @(posedge clk) begin : drive_words
    child_word_t next_word;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      in_hold = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        breed_child(s_axis_tdata[DRAW_BITS-1:0], s_axis_tlast);
        words_taken++;
        if (in_calm > 0) in_calm--;
        else if ($urandom_range(0, 39) == 0) in_calm = $urandom_range(10, 60);
        in_hold = (in_calm > 0) ? 0 : $urandom_range(0, 11);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (in_hold > 0) begin
          in_hold--;
          s_axis_tvalid <= 1'b0;
        end else if (child_words.size() != 0) begin
          next_word = child_words.pop_front();
          s_axis_tdata <= IN_DATA_W'(next_word.draw);
          s_axis_tlast <= next_word.last;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compare each census word with the oldest prediction, then stall a while.
  always @(posedge clk) begin : check_census
    census_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      out_hold = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_census.size() == 0) begin
          $error("census word with none predicted: tdata %h tuser %b", m_axis_tdata,
                 m_axis_tuser);
          mismatches++;
        end else begin
          want = pending_census.pop_front();
          if (m_axis_tdata[10:0] !== want.alive) begin
            $error("colors_alive: expected %0d, got %0d", want.alive, m_axis_tdata[10:0]);
            mismatches++;
          end
          if (m_axis_tdata[21:11] !== want.size) begin
            $error("generation_size: expected %0d, got %0d", want.size, m_axis_tdata[21:11]);
            mismatches++;
          end
          if (m_axis_tuser !== want.overflow) begin
            $error("size_overflow: expected %0d, got %0d", want.overflow, m_axis_tuser);
            mismatches++;
          end
        end
        if (out_calm > 0) out_calm--;
        else if ($urandom_range(0, 9) == 0) out_calm = $urandom_range(5, 20);
        out_hold = (out_calm > 0) ? 0 : $urandom_range(0, 11);
      end else if (out_hold > 0) begin
        out_hold--;
      end
      m_axis_tready <= (out_hold == 0);
    end
  end

  task automatic queue_word(input logic [DRAW_BITS-1:0] draw, input logic last);
    child_word_t w;
    w.draw = draw;
    w.last = last;
    child_words.push_back(w);
    words_queued++;
  endtask

  // A run of random children, closed by a last word if asked.
  task automatic queue_generation(input int count, input bit close);
    int k;
    for (k = 0; k < count; k++) queue_word(pick_draw(), close && (k == count - 1));
  endtask

  // Wait until every word is taken and every census is in, then let the block go quiet.
  task automatic drain_and_pause();
    while (words_taken != words_queued || pending_census.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_start(input logic [FIELD_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    reseed_population(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // A phase of random generations; some phases stop part way through a generation.
  task automatic random_phase(input logic [FIELD_W-1:0] value, input int gens);
    write_start(value);
    repeat (gens) begin
      queue_generation(($urandom_range(0, 7) == 0) ? $urandom_range(7, 40)
                                                   : $urandom_range(1, 6), 1'b1);
    end
    if ($urandom_range(0, 2) == 0) queue_generation($urandom_range(1, 3), 1'b0);
    drain_and_pause();
  endtask

  initial begin : stimulus
    logic [FIELD_W-1:0] starts [8];
    int                 p;
    reseed_population(FIELD_W'(1024));
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset population: extreme draws, wrap of the parent index, then tiny generations.
    queue_word('0, 1'b0);
    queue_word('1, 1'b0);
    queue_word(DRAW_BITS'(1023), 1'b0);
    queue_word(DRAW_BITS'(1024), 1'b0);
    queue_word(DRAW_BITS'(2047), 1'b1);
    queue_word('1, 1'b1);
    queue_word('0, 1'b0);
    queue_word(DRAW_BITS'(5), 1'b1);
    drain_and_pause();

    // A zero start size behaves as one individual.
    write_start('0);
    queue_word('1, 1'b0);
    queue_word(DRAW_BITS'(12345), 1'b0);
    queue_word('0, 1'b1);
    drain_and_pause();

    // An oversized start saturates; a new start drops the unfinished generation.
    write_start('1);
    queue_word('1, 1'b0);
    queue_word(DRAW_BITS'(777), 1'b0);
    drain_and_pause();
    write_start(FIELD_W'(2));
    queue_word(DRAW_BITS'(1), 1'b0);
    queue_word('0, 1'b0);
    queue_word(DRAW_BITS'(3), 1'b1);
    drain_and_pause();
    write_start(FIELD_W'(1024));
    queue_generation(4, 1'b1);
    drain_and_pause();

    // Random phases across a spread of start sizes.
    starts = '{FIELD_W'(1024), FIELD_W'(1), FIELD_W'(2), '1, '0, FIELD_W'(1023),
               FIELD_W'(512), FIELD_W'($urandom_range(1, 2047))};
    for (p = 0; p < 8; p++) random_phase(starts[p], $urandom_range(5, 10));

    // Many short generations in a row, enough to roll the colour stamps over.
    write_start(FIELD_W'(3));
    repeat (260) queue_generation($urandom_range(1, 2), 1'b1);
    drain_and_pause();

    // One generation past capacity, then a few drawn from the full population.
    write_start(FIELD_W'(1024));
    queue_generation(MAX_POP + $urandom_range(1, 5), 1'b1);
    repeat (3) queue_generation($urandom_range(1, 6), 1'b1);
    drain_and_pause();

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
